### src/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Types and constants shared by the nearest point search block.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

  localparam int NODE_DEPTH_DEF = 256;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 34;
  localparam int COUNT_W    = 9;
  localparam int DIST_W     = 34;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 1'd1;

  localparam logic [DIST_W-1:0] DIST_RESET = 34'd10000000;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] z;
  } point_t;

  typedef struct packed {
    logic               req_type;
    logic        [7:0]  slot;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [7:0]        nearest_slot;
    logic [DIST_W-1:0] nearest_distance;
  } out_item_t;

endpackage

`default_nettype wire

### src/nps_dist.sv
// ----------------------------------------------------------------------------
// nps_dist
// Three-stage squared planar distance: difference, square, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_dist #(
  parameter int AW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [AW-1:0]     in_idx,
  input  wire nps_pkg::point_t   node,
  input  wire nps_pkg::point_t   query,
  output logic                   out_valid,
  output logic [AW-1:0]          out_idx,
  output logic [32:0]            out_dist
);
  import nps_pkg::*;

  logic               a_valid;
  logic [AW-1:0]      a_idx;
  logic signed [16:0] a_dx;
  logic signed [16:0] a_dz;
  logic               b_valid;
  logic [AW-1:0]      b_idx;
  logic [31:0]        b_sqx;
  logic [31:0]        b_sqz;
  logic signed [33:0] px;
  logic signed [33:0] pz;

  assign px = a_dx * a_dx;
  assign pz = a_dz * a_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
    a_idx    <= in_idx;
    a_dx     <= {node.x[15], node.x} - {query.x[15], query.x};
    a_dz     <= {node.z[15], node.z} - {query.z[15], query.z};
    b_idx    <= a_idx;
    b_sqx    <= px[31:0];
    b_sqz    <= pz[31:0];
    out_idx  <= b_idx;
    out_dist <= {1'b0, b_sqx} + {1'b0, b_sqz};
  end

endmodule

`default_nettype wire

### src/nearest_point_search_2d_top.sv
// ----------------------------------------------------------------------------
// nearest_point_search_2d_top
// Node position table with a linear nearest-node scan in the x/z plane.
// ----------------------------------------------------------------------------
// Write item: no result; next item accepted the following cycle.
// Query item: scans min(node_count, NODE_DEPTH) entries, one table read per
//   cycle through a five-stage read/distance/compare path.
// One query at a time; a new item is taken while a result waits on out_stall.
// Reset: node_count 0, max_distance 10000000; table contents undefined.
`default_nettype none

module nearest_point_search_2d_top #(
  parameter int NODE_DEPTH = nps_pkg::NODE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire nps_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output nps_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [nps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [nps_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import nps_pkg::*;

  localparam int AW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int CW = $clog2(NODE_DEPTH + 1);
  localparam int MW = (CW > COUNT_W) ? CW : COUNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]        state;
  logic [COUNT_W-1:0] node_count;
  logic [DIST_W-1:0]  max_distance;

  logic [15:0] node_x_mem [NODE_DEPTH];
  logic [15:0] node_z_mem [NODE_DEPTH];

  logic              in_acc;
  logic [AW+7:0]     slot_ext;
  logic [MW-1:0]     count_ext;
  logic [CW-1:0]     limit_next;
  logic [CW-1:0]     limit;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     res_cnt;
  logic              issue;
  logic              rd_valid;
  logic [AW-1:0]     rd_idx;
  point_t            rd_pt;
  point_t            query;
  logic              d_valid;
  logic [AW-1:0]     d_idx;
  logic [32:0]       d_dist;
  logic [DIST_W-1:0] d_ext;
  logic [DIST_W-1:0] best;
  logic [AW-1:0]     best_slot;
  logic [AW+7:0]     best_slot_ext;
  logic              found;
  logic              out_load;

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_ext  = {{AW{1'b0}}, in_data.slot};
  assign count_ext = MW'(node_count);
  assign limit_next = (count_ext < MW'(NODE_DEPTH)) ? count_ext[CW-1:0] : CW'(NODE_DEPTH);
  assign issue     = (state == ST_SCAN) && (cnt != limit);
  assign d_ext     = {1'b0, d_dist};
  assign best_slot_ext = {8'd0, best_slot};
  assign out_load  = (state == ST_FIN) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count   <= '0;
      max_distance <= DIST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT:   node_count   <= cfg_data[COUNT_W-1:0];
        CFG_MAX_DISTANCE: max_distance <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.req_type == REQ_WRITE && slot_ext < (AW+8)'(NODE_DEPTH)) begin
      node_x_mem[slot_ext[AW-1:0]] <= in_data.coord_x;
      node_z_mem[slot_ext[AW-1:0]] <= in_data.coord_z;
    end
    if (issue) begin
      rd_pt.x <= node_x_mem[cnt[AW-1:0]];
      rd_pt.z <= node_z_mem[cnt[AW-1:0]];
    end
    rd_idx <= cnt[AW-1:0];
  end

  nps_dist #(
    .AW (AW)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_idx    (rd_idx),
    .node      (rd_pt),
    .query     (query),
    .out_valid (d_valid),
    .out_idx   (d_idx),
    .out_dist  (d_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc && in_data.req_type == REQ_QUERY) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (res_cnt == limit) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.req_type == REQ_QUERY) begin
      query.x   <= in_data.coord_x;
      query.z   <= in_data.coord_z;
      limit     <= limit_next;
      cnt       <= '0;
      res_cnt   <= '0;
      best      <= max_distance;
      best_slot <= '0;
      found     <= 1'b0;
    end else begin
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (d_valid) begin
        res_cnt <= res_cnt + 1'b1;
        if (d_ext <= best) begin
          best      <= d_ext;
          best_slot <= d_idx;
          found     <= 1'b1;
        end
      end
    end
    if (out_load) begin
      out_data.found            <= found;
      out_data.nearest_slot     <= best_slot_ext[7:0];
      out_data.nearest_distance <= best;
    end
  end

endmodule

`default_nettype wire

### src/nps_checker.sv
// ----------------------------------------------------------------------------
// nps_checker
// Port-level checks for the nearest point search block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire nps_pkg::in_item_t                 in_data,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire nps_pkg::out_item_t                out_data
);
  import nps_pkg::*;

  // held result item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // no node found means slot reads zero
  a_none_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.nearest_slot == 8'd0)
    else $error("nonzero slot without a found node");

  // a write item never blocks the next item
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.req_type == REQ_WRITE |=> !in_stall)
    else $error("stall after write item");

  // a query occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.req_type == REQ_QUERY |=> in_stall)
    else $error("no stall after query item");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nearest_point_search_2d_top nps_checker u_nps_checker (.*);

`default_nettype wire
